// File: rtl/ddsd_pkg.sv
// Shared types and constants of the display dirty span detector.
// Used by every module of the block; depends on nothing.
package ddsd_pkg;

	localparam int PAGE_WIDTH  = 128;
	localparam int PAGE_COUNT  = 8;
	localparam int BUF_BYTES   = PAGE_WIDTH * PAGE_COUNT;
	localparam int POS_W       = $clog2(BUF_BYTES);
	localparam int COL_W       = $clog2(PAGE_WIDTH);
	localparam int QUEUE_DEPTH = 4;
	localparam int QPTR_W      = $clog2(QUEUE_DEPTH);

	// Register file layout
	localparam int CFG_IDX_W  = 1;
	localparam int CFG_DATA_W = 7;
	localparam logic [CFG_IDX_W-1:0] CFG_GAP_LIMIT     = 1'd0;
	localparam logic [CFG_IDX_W-1:0] CFG_COLUMN_OFFSET = 1'd1;

	localparam logic [6:0] GAP_LIMIT_RST     = 7'd8;
	localparam logic [1:0] COLUMN_OFFSET_RST = 2'd2;

	// One classified framebuffer byte
	typedef struct packed {
		logic [POS_W-1:0] pos;
		logic [7:0]       pix;
		logic             frame_end;
		logic             page_end;
	} item_t;

	// One span descriptor
	typedef struct packed {
		logic [2:0] page;
		logic [7:0] column;
		logic [7:0] span_length;
		logic [9:0] start_index;
		logic       first_in_frame;
	} span_t;

	// Settings seen by the back end
	typedef struct packed {
		logic [6:0] gap_limit;
		logic [1:0] column_offset;
	} cfg_t;

endpackage

// File: rtl/display_dirty_span_detector.sv
// Top level of the display dirty span detector; uses ddsd_pkg, ddsd_front,
// ddsd_queue and ddsd_back. Throughput: one byte per cycle while pixel_stall is
// low, limited by the single shadow memory read and write port. The byte
// that closes a span passes the queue and read stage into the output register.
// Reset: asynchronous, clears control state; the shadow copy reads as zero
// through a fill mark, so no clearing pass is needed.
module display_dirty_span_detector import ddsd_pkg::*; (
	input  logic                  clk,
	input  logic                  arst_n,
	// configuration write port
	input  logic                  cfg_we,
	input  logic [CFG_IDX_W-1:0]  cfg_index,
	input  logic [CFG_DATA_W-1:0] cfg_data,
	// framebuffer byte channel
	input  logic                  pixel_valid,
	output logic                  pixel_stall,
	input  logic [7:0]            pixel_byte,
	input  logic                  frame_last,
	// span descriptor channel
	output logic                  span_valid,
	input  logic                  span_stall,
	output logic [2:0]            page,
	output logic [7:0]            column,
	output logic [7:0]            span_length,
	output logic [9:0]            start_index,
	output logic                  first_in_frame
);

	cfg_t  cfg_q;
	item_t front_item;
	item_t head_item;
	logic  queue_full;
	logic  push;
	logic  pop;
	logic  head_valid;
	span_t span;

	// Hold settings; the user must change them only while no byte is in flight (not enforced)
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.gap_limit     <= GAP_LIMIT_RST;
			cfg_q.column_offset <= COLUMN_OFFSET_RST;
		end else if (cfg_we) begin
			case (cfg_index)
				CFG_GAP_LIMIT:     cfg_q.gap_limit     <= cfg_data;
				CFG_COLUMN_OFFSET: cfg_q.column_offset <= cfg_data[1:0];
				default:           cfg_q <= cfg_q;
			endcase
		end
	end

	// Stall the byte channel only when the queue is full
	assign pixel_stall = queue_full;
	assign push        = pixel_valid && !queue_full;

	// Front: number and classify each transferred byte
	ddsd_front u_front (
		.clk        (clk),
		.arst_n     (arst_n),
		.push       (push),
		.pixel_byte (pixel_byte),
		.frame_last (frame_last),
		.item       (front_item)
	);

	// Decouple the front from the memory side
	ddsd_queue u_queue (
		.clk        (clk),
		.arst_n     (arst_n),
		.push       (push),
		.push_item  (front_item),
		.full       (queue_full),
		.pop        (pop),
		.head_valid (head_valid),
		.head_item  (head_item)
	);

	// Back: compare with the shadow copy, track and emit spans
	ddsd_back u_back (
		.clk        (clk),
		.arst_n     (arst_n),
		.cfg        (cfg_q),
		.head_valid (head_valid),
		.head_item  (head_item),
		.pop        (pop),
		.span_valid (span_valid),
		.span_stall (span_stall),
		.span       (span)
	);

	assign page           = span.page;
	assign column         = span.column;
	assign span_length    = span.span_length;
	assign start_index    = span.start_index;
	assign first_in_frame = span.first_in_frame;

endmodule

// File: rtl/ddsd_front.sv
// Front end: scan position counter and page/frame end classification.
// Depends on ddsd_pkg.
module ddsd_front import ddsd_pkg::*; (
	input  logic  clk,
	input  logic  arst_n,
	input  logic  push,
	input  logic  [7:0] pixel_byte,
	input  logic  frame_last,
	output item_t item
);

	logic [POS_W-1:0] pos_q;

	always_comb begin
		item.pos       = pos_q;
		item.pix       = pixel_byte;
		item.frame_end = frame_last || (pos_q == POS_W'(BUF_BYTES - 1));
		item.page_end  = (pos_q[COL_W-1:0] == COL_W'(PAGE_WIDTH - 1));
	end

	// Advance on every transfer, return to zero at frame end
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pos_q <= '0;
		end else if (push) begin
			pos_q <= item.frame_end ? '0 : pos_q + 1'b1;
		end
	end

endmodule

// File: rtl/ddsd_queue.sv
// Short FIFO of classified items between front and back end.
// Depends on ddsd_pkg.
module ddsd_queue import ddsd_pkg::*; (
	input  logic  clk,
	input  logic  arst_n,
	input  logic  push,
	input  item_t push_item,
	output logic  full,
	input  logic  pop,
	output logic  head_valid,
	output item_t head_item
);

	item_t                entry_q [QUEUE_DEPTH];
	logic [QPTR_W-1:0]    wr_ptr_q;
	logic [QPTR_W-1:0]    rd_ptr_q;
	logic [QPTR_W:0]      count_q;

	assign full       = (count_q == (QPTR_W+1)'(QUEUE_DEPTH));
	assign head_valid = (count_q != '0);
	assign head_item  = entry_q[rd_ptr_q];

	always_ff @(posedge clk) begin
		if (push) begin
			entry_q[wr_ptr_q] <= push_item;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (push) wr_ptr_q <= wr_ptr_q + 1'b1;
			if (pop)  rd_ptr_q <= rd_ptr_q + 1'b1;
			case ({push, pop})
				2'b10:   count_q <= count_q + 1'b1;
				2'b01:   count_q <= count_q - 1'b1;
				default: count_q <= count_q;
			endcase
		end
	end

endmodule

// File: rtl/ddsd_back.sv
// Back end: shadow memory read-compare-write, span tracking, output register.
// Depends on ddsd_pkg.
module ddsd_back import ddsd_pkg::*; (
	input  logic  clk,
	input  logic  arst_n,
	input  cfg_t  cfg,
	input  logic  head_valid,
	input  item_t head_item,
	output logic  pop,
	output logic  span_valid,
	input  logic  span_stall,
	output span_t span
);

	// Shadow copy; entries at or above the fill mark read as zero
	logic [7:0]       shadow_mem [BUF_BYTES];
	logic [7:0]       rd_data_q;
	logic [POS_W:0]   fill_q;

	// Stage holding the item whose shadow read is in flight
	logic             a_valid_q;
	item_t            a_item_q;
	logic             a_fwd_q;
	logic [7:0]       a_fwd_byte_q;
	logic             a_inrange_q;

	// Open span state
	logic [POS_W-1:0] first_q;
	logic [POS_W-1:0] final_q;
	logic             open_q;
	logic             fresh_q;

	logic             out_valid_q;
	span_t            out_q;

	logic [7:0]       old_byte;
	logic             changed;
	logic             open_n;
	logic [POS_W-1:0] first_n;
	logic [POS_W-1:0] final_n;
	logic [POS_W-1:0] gap;
	logic             close;
	logic             out_ready;
	logic             a_fire;
	logic             a_load;
	span_t            span_n;

	always_comb begin
		old_byte  = a_fwd_q ? a_fwd_byte_q : (a_inrange_q ? rd_data_q : 8'd0);
		changed   = (old_byte != a_item_q.pix);
		open_n    = open_q || changed;
		first_n   = (changed && !open_q) ? a_item_q.pos : first_q;
		final_n   = changed ? a_item_q.pos : final_q;
		gap       = a_item_q.pos - final_n;
		close     = open_n && ((gap > POS_W'(cfg.gap_limit))
			|| a_item_q.page_end || a_item_q.frame_end);
		out_ready = !out_valid_q || !span_stall;
		a_fire    = a_valid_q && (!close || out_ready);
		a_load    = head_valid && (!a_valid_q || a_fire);

		span_n.page           = 3'(first_n >> COL_W);
		span_n.column         = 8'(first_n[COL_W-1:0]) + 8'(cfg.column_offset);
		span_n.span_length    = 8'(final_n - first_n + 1'b1);
		span_n.start_index    = 10'(first_n);
		span_n.first_in_frame = fresh_q;
	end

	assign pop        = a_load;
	assign span_valid = out_valid_q;
	assign span       = out_q;

	// Shadow memory: write back on completion, read the next item on load
	always_ff @(posedge clk) begin
		if (a_fire) begin
			shadow_mem[a_item_q.pos] <= a_item_q.pix;
		end
		if (a_load) begin
			rd_data_q <= shadow_mem[head_item.pos];
		end
	end

	// Payload of the read stage; forward a same-address write
	always_ff @(posedge clk) begin
		if (a_load) begin
			a_item_q     <= head_item;
			a_fwd_q      <= a_fire && (head_item.pos == a_item_q.pos);
			a_fwd_byte_q <= a_item_q.pix;
			a_inrange_q  <= ({1'b0, head_item.pos} < fill_q);
		end
		if (a_fire && close) begin
			out_q <= span_n;
		end
		if (a_fire) begin
			first_q <= first_n;
			final_q <= final_n;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			a_valid_q   <= 1'b0;
			fill_q      <= '0;
			open_q      <= 1'b0;
			fresh_q     <= 1'b1;
			out_valid_q <= 1'b0;
		end else begin
			if (a_load) begin
				a_valid_q <= 1'b1;
			end else if (a_fire) begin
				a_valid_q <= 1'b0;
			end
			if (a_fire) begin
				if (({1'b0, a_item_q.pos} + 1'b1) > fill_q) begin
					fill_q <= {1'b0, a_item_q.pos} + 1'b1;
				end
				open_q <= open_n && !close;
				if (a_item_q.frame_end) begin
					fresh_q <= 1'b1;
				end else if (close) begin
					fresh_q <= 1'b0;
				end
			end
			if (a_fire && close) begin
				out_valid_q <= 1'b1;
			end else if (!span_stall) begin
				out_valid_q <= 1'b0;
			end
		end
	end

endmodule
